// ----- src/rsfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfl_pkg
// shared types and constants of the relocated symbol floor lookup
// ----------------------------------------------------------------------------
package rsfl_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 5;

	// opcodes of an input word
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// register indexes
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_TEXT_ORIGIN = 2'd1;
	localparam logic [1:0] REG_RUN_BASE    = 2'd2;
	localparam logic [1:0] REG_RUN_END     = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [ADDR_W-1:0] entry_value;
		logic [ADDR_W-1:0] lookup_address;
	} in_word_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  symbol_index;
		logic [ADDR_W-1:0] next_symbol_address;
	} out_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]  entry_count;
		logic [ADDR_W-1:0] text_origin;
		logic [ADDR_W-1:0] run_base;
		logic [ADDR_W-1:0] run_end;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_ENDS,
		ST_PROBE_RD,
		ST_PROBE_CMP,
		ST_RB_SUB,
		ST_RB_ADD,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic write_entry;
		logic load_lookup;
		logic calc_key;
		logic rd_probe;
		logic set_miss;
		logic set_last;
		logic set_nomatch;
		logic set_found;
		logic narrow;
		logic rb_sub;
		logic rb_add;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic key_lt_a;
		logic key_ge_b;
		logic found;
		logic lo_eq_hi;
	} dp_stat_t;

endpackage

// ----- src/rsfl_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfl_cfg
// apb register file: entry count, text origin, load base, load end
// ----------------------------------------------------------------------------
module rsfl_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rsfl_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rsfl_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [rsfl_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output rsfl_pkg::cfg_t                      cfg
);
	import rsfl_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[CFG_ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_count <= CNT_W'(1);
			cfg_q.text_origin <= '0;
			cfg_q.run_base    <= '0;
			cfg_q.run_end     <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ENTRY_COUNT: cfg_q.entry_count <= pwdata[CNT_W-1:0];
				REG_TEXT_ORIGIN: cfg_q.text_origin <= pwdata[ADDR_W-1:0];
				REG_RUN_BASE:    cfg_q.run_base    <= pwdata[ADDR_W-1:0];
				REG_RUN_END:     cfg_q.run_end     <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_ENTRY_COUNT: prdata = CFG_DATA_W'(cfg_q.entry_count);
			REG_TEXT_ORIGIN: prdata = CFG_DATA_W'(cfg_q.text_origin);
			REG_RUN_BASE:    prdata = CFG_DATA_W'(cfg_q.run_base);
			REG_RUN_END:     prdata = CFG_DATA_W'(cfg_q.run_end);
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- src/rsfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfl_ctrl
// sequencer of the lookup: relocation, end checks, probe loop, back-relocation
// ----------------------------------------------------------------------------
module rsfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               opcode,
	input  rsfl_pkg::dp_stat_t stat,
	output rsfl_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               out_strobe
);
	import rsfl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		out_strobe = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == OP_LOOKUP) begin
						cmd.load_lookup = 1'b1;
						state_d         = ST_KEY;
					end else begin
						cmd.write_entry = 1'b1;
					end
				end
			end
			ST_KEY: begin
				cmd.calc_key = 1'b1;
				state_d      = ST_ENDS;
			end
			ST_ENDS: begin
				if (stat.key_lt_a) begin
					cmd.set_miss = 1'b1;
					state_d      = ST_RB_SUB;
				end else if (stat.key_ge_b) begin
					cmd.set_last = 1'b1;
					state_d      = ST_DONE;
				end else begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_PROBE_RD: begin
				if (stat.lo_eq_hi) begin
					cmd.set_nomatch = 1'b1;
					state_d         = ST_DONE;
				end else begin
					cmd.rd_probe = 1'b1;
					state_d      = ST_PROBE_CMP;
				end
			end
			ST_PROBE_CMP: begin
				if (stat.found) begin
					cmd.set_found = 1'b1;
					state_d       = ST_RB_SUB;
				end else begin
					cmd.narrow = 1'b1;
					state_d    = ST_PROBE_RD;
				end
			end
			ST_RB_SUB: begin
				cmd.rb_sub = 1'b1;
				state_d    = ST_RB_ADD;
			end
			ST_RB_ADD: begin
				cmd.rb_add = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				out_strobe = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- src/rsfl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfl_dp
// symbol table memory, search bounds, key and address arithmetic
// ----------------------------------------------------------------------------
module rsfl_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rsfl_pkg::in_word_t  in_word,
	input  rsfl_pkg::cfg_t      cfg,
	input  rsfl_pkg::dp_cmd_t   cmd,
	output rsfl_pkg::dp_stat_t  stat,
	output rsfl_pkg::out_word_t out_word
);
	import rsfl_pkg::*;

	logic [ADDR_W-1:0] mem [TABLE_DEPTH];

	logic [ADDR_W-1:0] diff_q;
	logic [ADDR_W-1:0] key_q;
	logic [ADDR_W-1:0] rd_a_q;
	logic [ADDR_W-1:0] rd_b_q;
	logic [ADDR_W-1:0] link_q;
	logic [ADDR_W-1:0] next_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [IDX_W-1:0]  sym_q;
	logic              hit_q;

	logic [IDX_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [IDX_W-1:0]  mid_p1;
	logic [IDX_W-1:0]  last_idx;
	logic [IDX_W-1:0]  rd_addr_a;
	logic [IDX_W-1:0]  rd_addr_b;
	logic              rd_en;

	// last used entry: zero count acts as one, large count saturates
	always_comb begin
		if (cfg.entry_count == '0) begin
			last_idx = '0;
		end else if (cfg.entry_count > CNT_W'(TABLE_DEPTH)) begin
			last_idx = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			last_idx = IDX_W'(cfg.entry_count - CNT_W'(1));
		end
	end

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IDX_W:1];
	assign mid_p1    = mid + IDX_W'(1);
	assign rd_en     = cmd.calc_key | cmd.rd_probe;
	assign rd_addr_a = cmd.rd_probe ? mid : '0;
	assign rd_addr_b = cmd.rd_probe ? mid_p1 : hi_q;

	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			mem[in_word.entry_index] <= in_word.entry_value;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_lookup) begin
			diff_q <= in_word.lookup_address - cfg.run_base;
			lo_q   <= '0;
			hi_q   <= last_idx;
		end
		if (cmd.calc_key) begin
			key_q <= cfg.text_origin + diff_q;
		end
		if (cmd.narrow) begin
			if (rd_a_q > key_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid_p1;
			end
		end
		if (cmd.set_miss) begin
			link_q <= rd_a_q;
		end else if (cmd.set_found) begin
			link_q <= rd_b_q;
		end else if (cmd.rb_sub) begin
			link_q <= link_q - cfg.text_origin;
		end
		if (cmd.rb_add) begin
			next_q <= cfg.run_base + link_q;
		end else if (cmd.set_last) begin
			next_q <= cfg.run_end;
		end else if (cmd.set_nomatch) begin
			next_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			sym_q <= '0;
		end else if (cmd.set_miss | cmd.set_nomatch) begin
			hit_q <= 1'b0;
			sym_q <= '0;
		end else if (cmd.set_last) begin
			hit_q <= 1'b1;
			sym_q <= hi_q;
		end else if (cmd.set_found) begin
			hit_q <= 1'b1;
			sym_q <= mid;
		end
	end

	assign stat.key_lt_a = (key_q < rd_a_q);
	assign stat.key_ge_b = (key_q >= rd_b_q);
	assign stat.found    = (rd_a_q <= key_q) & (rd_b_q > key_q);
	assign stat.lo_eq_hi = (lo_q == hi_q);

	assign out_word.hit                 = hit_q;
	assign out_word.symbol_index        = sym_q;
	assign out_word.next_symbol_address = next_q;

endmodule

// ----- src/relocated_symbol_floor_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relocated_symbol_floor_lookup
// floor search of a runtime address in a table of link-time symbol starts
// ----------------------------------------------------------------------------
// A write word (opcode write) stores entry_value at entry_index; busy stays
// low and no result word follows. A lookup word relocates the address to
// text_origin + (lookup_address - run_base), checks the first and last used
// entries, then binary-searches. Each probe first reads entries mid and
// mid+1 from the two read ports of the table memory, then compares them
// with the key. A lookup holds busy high and ends with out_strobe high for
// exactly one cycle with out_word valid in that cycle only. The receiver
// cannot stall: capture out_word when out_strobe is high. Configuration
// registers sit at byte addresses 0, 8, 16 and 24 and may only be written
// while busy is low.
// ----------------------------------------------------------------------------
module relocated_symbol_floor_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	// item port
	input  logic                            start,
	output logic                            busy,
	input  rsfl_pkg::in_word_t              in_word,
	// result port, one cycle strobe
	output logic                            out_strobe,
	output rsfl_pkg::out_word_t             out_word,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rsfl_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rsfl_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rsfl_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import rsfl_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// register file
	rsfl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accepts words, steps the search, raises the strobe
	rsfl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (in_word.opcode),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.out_strobe (out_strobe)
	);

	// table memory, bounds, key and address arithmetic, result registers
	rsfl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cfg      (cfg),
		.cmd      (cmd),
		.stat     (stat),
		.out_word (out_word)
	);

endmodule

// ----- src/rsfl_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfl_chk
// port-level checks of the lookup block, bound to the top level
// ----------------------------------------------------------------------------
module rsfl_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input rsfl_pkg::in_word_t  in_word,
	input logic                out_strobe,
	input rsfl_pkg::out_word_t out_word
);
	import rsfl_pkg::*;

	// a result only ends a lookup in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> busy)
		else $error("result strobe while idle");

	// the block is idle right after a result
	a_strobe_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |=> (!out_strobe && !busy))
		else $error("block not idle after result");

	// a table write completes in its accept cycle
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && in_word.opcode == OP_WRITE) |=> (!busy && !out_strobe))
		else $error("write word made the block busy");

	// a lookup always goes busy
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && in_word.opcode == OP_LOOKUP) |=> busy)
		else $error("lookup word not taken");

	// a miss reports index zero
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_strobe && !out_word.hit) |-> (out_word.symbol_index == '0))
		else $error("miss with nonzero index");

endmodule

bind relocated_symbol_floor_lookup rsfl_chk u_rsfl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.in_word    (in_word),
	.out_strobe (out_strobe),
	.out_word   (out_word)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the relocated symbol floor lookup
// ----------------------------------------------------------------------------
// A clocked driver takes table writes and address lookups from a queue that
// the stimulus process fills one phase at a time. A clocked monitor compares
// each result word with a floor search that the bench runs over its own
// mirror of the table and the registers. Between phases all outstanding
// results are drained, then the registers are written over the register port
// and read back. A short directed part covers the corner cases. Random phases
// follow: mostly ascending tables with keys placed on, next to, below and
// above the entries, plus some broken ordering and stray addresses.
// ----------------------------------------------------------------------------
module tb;
	import rsfl_pkg::*;

	// long enough to cover any word still inside the block
	localparam int SETTLE_CYCLES = 30;
	// cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT   = 2000;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  start   = 1'b0;
	logic                  busy;
	in_word_t              in_word = '0;
	logic                  out_strobe;
	out_word_t             out_word;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// table contents as the block should hold them after each accepted word
	logic [ADDR_W-1:0] sym_table [TABLE_DEPTH];
	// table contents as the queued writes will leave them, used to aim keys
	logic [ADDR_W-1:0] plan_table [TABLE_DEPTH];

	// register mirror
	logic [CNT_W-1:0]  reg_count  = 11'd1;
	logic [ADDR_W-1:0] reg_origin = '0;
	logic [ADDR_W-1:0] reg_base   = '0;
	logic [ADDR_W-1:0] reg_end    = '0;

	in_word_t  pending_words [$];
	out_word_t lookup_results_due [$];

	int sender_idle_pct = 10;
	int errors          = 0;
	int words_accepted  = 0;
	int lookups_checked = 0;
	int settings_done   = 0;
	int written_upto    = 0;   // leading entries known to be written
	int stall_cycles    = 0;

	relocated_symbol_floor_lookup dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.in_word    (in_word),
		.out_strobe (out_strobe),
		.out_word   (out_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// register values, with the extremes now and then
	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return rnd64();
		endcase
	endfunction

	// link-time address to runtime address; also turns a key into the
	// lookup address that relocates onto it
	function automatic logic [ADDR_W-1:0] to_runtime(logic [ADDR_W-1:0] link);
		return reg_base + (link - reg_origin);
	endfunction

	function automatic out_word_t floor_search(logic [ADDR_W-1:0] addr);
		out_word_t         r;
		logic [ADDR_W-1:0] key;
		int                lo;
		int                hi;
		int                mid;
		r   = '0;
		key = reg_origin + (addr - reg_base);
		lo  = 0;
		// a count of zero acts as one, a count past the depth saturates
		if (reg_count == 0) begin
			hi = 0;
		end else if (reg_count > TABLE_DEPTH) begin
			hi = TABLE_DEPTH - 1;
		end else begin
			hi = reg_count - 1;
		end
		if (key < sym_table[0]) begin
			// miss below the table: next is the first symbol
			r.next_symbol_address = to_runtime(sym_table[0]);
		end else if (key >= sym_table[hi]) begin
			// at or past the last symbol: next is the module end
			r.hit                 = 1'b1;
			r.symbol_index        = hi[IDX_W-1:0];
			r.next_symbol_address = reg_end;
		end else begin
			// narrow until an adjacent pair brackets the key; an unordered
			// table may leave no such pair, which gives an all-zero word
			while (lo != hi && !r.hit) begin
				mid = (lo + hi) / 2;
				if (sym_table[mid] <= key && sym_table[mid + 1] > key) begin
					r.hit                 = 1'b1;
					r.symbol_index        = mid[IDX_W-1:0];
					r.next_symbol_address = to_runtime(sym_table[mid + 1]);
				end else if (sym_table[mid] > key) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
		end
		return r;
	endfunction

	// driver: a word is taken at an edge with start high and busy low; the
	// next one is loaded at that same edge unless the sender idles
	always @(posedge clk) begin : drive_words
		if (arst_n) begin
			if (start && !busy) begin
				words_accepted++;
				if (in_word.opcode == OP_WRITE) begin
					sym_table[in_word.entry_index] = in_word.entry_value;
				end else begin
					lookup_results_due.push_back(floor_search(in_word.lookup_address));
				end
			end
			// idle decisions also fall while a lookup is running
			if (!start || !busy) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_word <= pending_words.pop_front();
					start   <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: the strobe cannot be held off, so every strobe is a result
	always @(posedge clk) begin : check_results
		out_word_t due;
		if (arst_n && out_strobe) begin
			if (lookup_results_due.size() == 0) begin
				$error("result word with no lookup outstanding");
				errors++;
			end else begin
				due = lookup_results_due.pop_front();
				lookups_checked++;
				if (out_word.hit !== due.hit) begin
					$error("hit: expected %0d, got %0d", due.hit, out_word.hit);
					errors++;
				end
				if (out_word.symbol_index !== due.symbol_index) begin
					$error("symbol_index: expected %0d, got %0d",
						due.symbol_index, out_word.symbol_index);
					errors++;
				end
				if (out_word.next_symbol_address !== due.next_symbol_address) begin
					$error("next_symbol_address: expected %h, got %h",
						due.next_symbol_address, out_word.next_symbol_address);
					errors++;
				end
			end
		end
	end

	// watchdog on handshakes of any kind
	always @(posedge clk) begin
		if ((start && !busy) || out_strobe || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$error("no handshake for %0d cycles", STALL_LIMIT);
			$display("FAIL relocated_symbol_floor_lookup");
			$finish;
		end
	end

	task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		in_word_t w;
		w             = '0;
		w.opcode      = OP_WRITE;
		w.entry_index = idx;
		w.entry_value = val;
		plan_table[idx] = val;
		pending_words.push_back(w);
	endtask

	task automatic queue_lookup(input logic [ADDR_W-1:0] addr);
		in_word_t w;
		w                = '0;
		w.opcode         = OP_LOOKUP;
		w.lookup_address = addr;
		pending_words.push_back(w);
	endtask

	// write one register, then read it straight back in the next transfer
	task automatic set_register(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
		logic [ADDR_W-1:0] want;
		string             rname;
		want = val;
		case (idx)
			REG_ENTRY_COUNT: begin
				want                = '0;
				want[CNT_W-1:0]     = val[CNT_W-1:0];
				reg_count           = val[CNT_W-1:0];
				rname               = "entry_count";
			end
			REG_TEXT_ORIGIN: begin
				reg_origin = val;
				rname      = "text_origin";
			end
			REG_RUN_BASE: begin
				reg_base = val;
				rname    = "run_base";
			end
			default: begin
				reg_end = val;
				rname   = "run_end";
			end
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		// register takes the value here; read setup follows directly
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (prdata !== want) begin
			$error("%s: expected %h, got %h", rname, want, prdata);
			errors++;
		end
	endtask

	// sender holds off until every queued word is taken and every result is in
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_words.size() != 0 || start || busy || lookup_results_due.size() != 0);
		// a table write leaves nothing due but may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register setting, an optional fresh table, then aimed lookups
	task automatic table_phase(input int count_cfg, input int n_lookups, input bit reload);
		logic [ADDR_W-1:0] v;
		logic [ADDR_W-1:0] key;
		logic [ADDR_W-1:0] val;
		int                used;
		int                j;
		int                k;
		bit                down;
		// junk in the upper bits of the count write must be dropped
		val            = rnd64();
		val[CNT_W-1:0] = count_cfg[CNT_W-1:0];
		set_register(REG_ENTRY_COUNT, val);
		set_register(REG_TEXT_ORIGIN, pick_addr());
		set_register(REG_RUN_BASE, pick_addr());
		set_register(REG_RUN_END, pick_addr());
		settings_done++;
		used = (count_cfg == 0) ? 1 : (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : count_cfg;
		@(negedge clk);
		if (reload) begin
			v = rnd64();
			// headroom so 1024 steps below 2^40 never wrap
			if (&v[ADDR_W-1:51]) v[ADDR_W-1] = 1'b0;
			for (k = 0; k < used; k++) begin
				plan_table[k] = v;
				// an occasional zero step gives equal neighbors
				v = v + (($urandom_range(15) == 0) ? 64'd0 : (rnd64() >> $urandom_range(24, 63)));
			end
			down = $urandom_range(1);
			for (k = 0; k < used; k++) begin
				j = down ? used - 1 - k : k;
				queue_write(j[IDX_W-1:0], plan_table[j]);
			end
			// now and then break the ordering
			if ($urandom_range(4) == 0) begin
				j = $urandom_range(used - 1);
				queue_write(j[IDX_W-1:0], rnd64());
			end
			if (used > written_upto) written_upto = used;
		end
		for (k = 0; k < n_lookups; k++) begin
			j = $urandom_range(used - 1);
			case ($urandom_range(19))
				0: begin
					// same value again, the table is unchanged
					queue_write(j[IDX_W-1:0], plan_table[j]);
				end
				1, 2, 3: begin
					// just below the first entry, wraps when it is zero
					key = plan_table[0] - 64'd1 - $urandom_range(3);
					queue_lookup(to_runtime(key));
				end
				4, 5: begin
					key = plan_table[used - 1] + $urandom_range(3);
					queue_lookup(to_runtime(key));
				end
				6, 7: begin
					queue_lookup(rnd64());
				end
				default: begin
					case ($urandom_range(3))
						0: key = plan_table[j];
						1: key = plan_table[j] - 64'd1;
						2: key = plan_table[j] + 64'd1;
						default: key = plan_table[j] + (rnd64() >> $urandom_range(20, 63));
					endcase
					queue_lookup(to_runtime(key));
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int ph;
		int cnt;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one entry, identity relocation, load end zero
		@(negedge clk);
		queue_write(10'd0, 64'h8000_0000_0000_0000);
		queue_lookup('0);                        // below the only entry
		queue_lookup('1);                        // past it, load end follows
		queue_lookup(64'h8000_0000_0000_0000);   // exactly on it
		wait_idle();

		// four entries with extreme values, relocation that wraps both ways
		set_register(REG_ENTRY_COUNT, 64'd4);
		set_register(REG_TEXT_ORIGIN, 64'hFFFF_FFFF_FFFF_F000);
		set_register(REG_RUN_BASE, 64'h0000_0000_0000_1000);
		set_register(REG_RUN_END, '1);
		settings_done++;
		@(negedge clk);
		queue_write(10'd0, 64'h0);
		queue_write(10'd1, 64'h10);
		queue_write(10'd2, 64'h5555_5555_5555_5555);
		queue_write(10'd3, '1);
		queue_write(10'd1023, 64'h0123_4567_89AB_CDEF);   // top index, not in use
		queue_lookup(to_runtime(64'h0F));
		queue_lookup(to_runtime(64'h10));
		queue_lookup(to_runtime(64'h5555_5555_5555_5554));
		queue_lookup(to_runtime(64'h5555_5555_5555_5555));
		queue_lookup(to_runtime('1));            // last entry
		// table out of order: entry 1 above entry 2
		queue_write(10'd1, 64'h6000_0000_0000_0000);
		queue_lookup(to_runtime(64'h5600_0000_0000_0000));
		wait_idle();

		// a count of zero behaves as one entry
		set_register(REG_ENTRY_COUNT, 64'd0);
		settings_done++;
		@(negedge clk);
		queue_write(10'd0, 64'h100);
		queue_lookup(to_runtime(64'hFF));        // miss, next wraps around
		queue_lookup(to_runtime(64'h100));
		wait_idle();
		written_upto = 4;

		// small random tables: sender idles 10 percent, then 74 percent
		for (ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph < 2) ? 10 : 74;
			if (ph == 3) begin
				// reuse whatever is already written
				table_phase($urandom_range(1, written_upto), $urandom_range(10, 30), 1'b0);
			end else begin
				case (ph)
					0: cnt = 1;
					1: cnt = $urandom_range(1, 40);
					default: cnt = $urandom_range(1, 100);
				endcase
				table_phase(cnt, $urandom_range(10, 30), 1'b1);
			end
			wait_idle();
		end

		// full depth with no sender idling, then a count past the depth
		// on the same table
		sender_idle_pct = 0;
		table_phase(TABLE_DEPTH, 60, 1'b1);
		wait_idle();
		table_phase(2047, 30, 1'b0);
		wait_idle();

		$display("checked %0d lookup results in %0d words over %0d register settings",
			lookups_checked, words_accepted, settings_done);
		$display("tables of 1 to %0d entries, zero and saturated counts, unordered tables",
			TABLE_DEPTH);
		if (errors == 0) begin
			$display("PASS relocated_symbol_floor_lookup");
		end else begin
			$display("FAIL relocated_symbol_floor_lookup");
		end
		$finish;
	end

endmodule
